@@ rtl/tpi_pkg.sv @@
// tpi_pkg: beat types, widths and the divider lane record for the three-plane intersection
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps

package tpi_pkg;

  localparam int NW     = 16;  // normal component, q2.14
  localparam int DISTW  = 32;  // plane distance and point, q16.16
  localparam int CW     = 33;  // cross product component, q5.28
  localparam int DENW   = 50;  // triple product, signed
  localparam int NUMW   = 66;  // numerator sum, signed
  localparam int DW     = 49;  // triple product magnitude
  localparam int MW     = 79;  // numerator magnitude with fraction alignment
  localparam int QW     = 32;  // quotient bits produced by the divider
  localparam int FRAC_SHIFT = 14;

  typedef logic signed [CW-1:0]   cross_t;
  typedef logic signed [DENW-1:0] den_t;
  typedef logic signed [NUMW-1:0] num_t;

  typedef struct packed {
    logic signed [NW-1:0]    a_nx;
    logic signed [NW-1:0]    a_ny;
    logic signed [NW-1:0]    a_nz;
    logic signed [DISTW-1:0] a_dist;
    logic signed [NW-1:0]    b_nx;
    logic signed [NW-1:0]    b_ny;
    logic signed [NW-1:0]    b_nz;
    logic signed [DISTW-1:0] b_dist;
    logic signed [NW-1:0]    c_nx;
    logic signed [NW-1:0]    c_ny;
    logic signed [NW-1:0]    c_nz;
    logic signed [DISTW-1:0] c_dist;
  } in_item_t;

  typedef struct packed {
    logic signed [DISTW-1:0] px;
    logic signed [DISTW-1:0] py;
    logic signed [DISTW-1:0] pz;
    logic                    found;
    logic                    saturated;
  } out_item_t;

  // one coordinate in flight through the divider
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] rest;
    logic [QW-1:0] q;
    logic [DW-1:0] dmag;
    logic          rneg;
    logic          ovf;
  } div_lane_t;

  typedef struct packed {
    logic valid;
    logic found;
  } front_ctl_t;

endpackage

@@ rtl/tpi_if.sv @@
// tpi_if: valid/ready channels for plane triples and intersection points
// depends on tpi_pkg for the payload types
`timescale 1ns / 1ps

interface tpi_in_if;
  logic               valid;
  logic               ready;
  tpi_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpi_out_if;
  logic               valid;
  logic               ready;
  tpi_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tpi_front.sv @@
// tpi_front: cross products, triple product, numerators and magnitudes (five stages)
// depends on tpi_pkg; feeds three tpi_div lanes
`timescale 1ns / 1ps

module tpi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  tpi_pkg::in_item_t   in_item,
  output tpi_pkg::div_lane_t  lane_o [3],
  output tpi_pkg::front_ctl_t ctl_o
);

  function automatic tpi_pkg::cross_t cross_comp(
    input logic signed [tpi_pkg::NW-1:0] a,
    input logic signed [tpi_pkg::NW-1:0] b,
    input logic signed [tpi_pkg::NW-1:0] c,
    input logic signed [tpi_pkg::NW-1:0] d
  );
    cross_comp = (tpi_pkg::CW'(a) * tpi_pkg::CW'(b)) - (tpi_pkg::CW'(c) * tpi_pkg::CW'(d));
  endfunction

  logic [4:0] v_r;

  // stage 1
  tpi_pkg::cross_t c23_r [3];
  tpi_pkg::cross_t c31_r [3];
  tpi_pkg::cross_t c12_r [3];
  logic signed [tpi_pkg::NW-1:0]    n1_r [3];
  logic signed [tpi_pkg::DISTW-1:0] d1_r [3];
  // stage 2
  tpi_pkg::den_t dp_r [3];
  tpi_pkg::num_t np_r [3][3];
  // stage 3
  tpi_pkg::den_t den_r;
  tpi_pkg::num_t num_r [3];
  // stage 4
  logic [tpi_pkg::MW-1:0] mag_r [3];
  logic [tpi_pkg::DW-1:0] dmag_r;
  logic                   rneg_r [3];
  logic                   found4_r;
  logic                   found5_r;
  // stage 5
  tpi_pkg::div_lane_t lane_r [3];

  logic [tpi_pkg::MW-1:0] mag_nxt [3];
  logic [tpi_pkg::DW-1:0] dmag_nxt;
  logic                   rneg_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_comb begin
    tpi_pkg::den_t dabs;
    tpi_pkg::num_t nabs;
    dabs = den_r[tpi_pkg::DENW-1] ? -den_r : den_r;
    dmag_nxt = dabs[tpi_pkg::DW-1:0];
    for (int k = 0; k < 3; k++) begin
      nabs = num_r[k][tpi_pkg::NUMW-1] ? -num_r[k] : num_r[k];
      mag_nxt[k] = {nabs[tpi_pkg::MW-tpi_pkg::FRAC_SHIFT-1:0], {tpi_pkg::FRAC_SHIFT{1'b0}}};
      // point is minus numerator over denominator
      rneg_nxt[k] = (num_r[k][tpi_pkg::NUMW-1] == den_r[tpi_pkg::DENW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c23_r[0] <= cross_comp(in_item.b_ny, in_item.c_nz, in_item.b_nz, in_item.c_ny);
      c23_r[1] <= cross_comp(in_item.b_nz, in_item.c_nx, in_item.b_nx, in_item.c_nz);
      c23_r[2] <= cross_comp(in_item.b_nx, in_item.c_ny, in_item.b_ny, in_item.c_nx);
      c31_r[0] <= cross_comp(in_item.c_ny, in_item.a_nz, in_item.c_nz, in_item.a_ny);
      c31_r[1] <= cross_comp(in_item.c_nz, in_item.a_nx, in_item.c_nx, in_item.a_nz);
      c31_r[2] <= cross_comp(in_item.c_nx, in_item.a_ny, in_item.c_ny, in_item.a_nx);
      c12_r[0] <= cross_comp(in_item.a_ny, in_item.b_nz, in_item.a_nz, in_item.b_ny);
      c12_r[1] <= cross_comp(in_item.a_nz, in_item.b_nx, in_item.a_nx, in_item.b_nz);
      c12_r[2] <= cross_comp(in_item.a_nx, in_item.b_ny, in_item.a_ny, in_item.b_nx);
      n1_r[0]  <= in_item.a_nx;
      n1_r[1]  <= in_item.a_ny;
      n1_r[2]  <= in_item.a_nz;
      d1_r[0]  <= in_item.a_dist;
      d1_r[1]  <= in_item.b_dist;
      d1_r[2]  <= in_item.c_dist;

      for (int k = 0; k < 3; k++) begin
        dp_r[k]    <= tpi_pkg::DENW'(n1_r[k]) * tpi_pkg::DENW'(c23_r[k]);
        np_r[k][0] <= tpi_pkg::NUMW'(d1_r[0]) * tpi_pkg::NUMW'(c23_r[k]);
        np_r[k][1] <= tpi_pkg::NUMW'(d1_r[1]) * tpi_pkg::NUMW'(c31_r[k]);
        np_r[k][2] <= tpi_pkg::NUMW'(d1_r[2]) * tpi_pkg::NUMW'(c12_r[k]);
      end

      den_r <= dp_r[0] + dp_r[1] + dp_r[2];
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= np_r[k][0] + np_r[k][1] + np_r[k][2];
      end

      dmag_r   <= dmag_nxt;
      found4_r <= (den_r != '0);
      for (int k = 0; k < 3; k++) begin
        mag_r[k]  <= mag_nxt[k];
        rneg_r[k] <= rneg_nxt[k];
      end

      // quotient of 2^32 or more is flagged here; otherwise the top bits seed the remainder
      found5_r <= found4_r;
      for (int k = 0; k < 3; k++) begin
        lane_r[k].rem  <= tpi_pkg::DW'(mag_r[k][tpi_pkg::MW-1:tpi_pkg::QW]);
        lane_r[k].rest <= mag_r[k][tpi_pkg::QW-1:0];
        lane_r[k].q    <= '0;
        lane_r[k].dmag <= dmag_r;
        lane_r[k].rneg <= rneg_r[k];
        lane_r[k].ovf  <= (tpi_pkg::DW'(mag_r[k][tpi_pkg::MW-1:tpi_pkg::QW]) >= dmag_r);
      end
    end
  end

  assign lane_o = lane_r;
  assign ctl_o  = '{valid: v_r[4], found: found5_r};

endmodule

@@ rtl/tpi_div.sv @@
// tpi_div: one restoring divider lane, one quotient bit per pipeline stage
// depends on tpi_pkg for the lane record
`timescale 1ns / 1ps

module tpi_div (
  input  logic               clk,
  input  logic               en,
  input  tpi_pkg::div_lane_t lane_i,
  output tpi_pkg::div_lane_t lane_o
);

  function automatic tpi_pkg::div_lane_t div_step(input tpi_pkg::div_lane_t s);
    logic [tpi_pkg::DW:0] t;
    logic                 ge;
    tpi_pkg::div_lane_t   r;
    t  = {s.rem, s.rest[tpi_pkg::QW-1]};
    ge = (t >= {1'b0, s.dmag});
    r  = s;
    r.rem  = ge ? tpi_pkg::DW'(t - {1'b0, s.dmag}) : t[tpi_pkg::DW-1:0];
    r.rest = {s.rest[tpi_pkg::QW-2:0], 1'b0};
    r.q    = {s.q[tpi_pkg::QW-2:0], ge};
    return r;
  endfunction

  tpi_pkg::div_lane_t st_r [tpi_pkg::QW];

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_step(lane_i);
      for (int i = 1; i < tpi_pkg::QW; i++) begin
        st_r[i] <= div_step(st_r[i-1]);
      end
    end
  end

  assign lane_o = st_r[tpi_pkg::QW-1];

endmodule

@@ rtl/three_plane_intersection.sv @@
// three_plane_intersection: top level, intersection point of three planes
// depends on tpi_pkg, tpi_if, tpi_front and tpi_div
//
//   channel  dir  beat contents
//   in_ch    in   three planes: normals q2.14, distances q16.16
//   out_ch   out  point px/py/pz q16.16, found, saturated
//
// one beat in and one beat out per cycle sustained while the output is not stalled; a beat passes
// through five front stages, 32 divider stages at one quotient bit each, and the output register
// the 32-stage restoring divider sets the depth; the cross and triple products set the width
// reset clears the valid bits only; payload registers are left as they are
// a stalled output beat freezes the whole pipeline, nothing is dropped or repeated
`timescale 1ns / 1ps

module three_plane_intersection (
  input logic        clk,
  input logic        rst_n,
  tpi_in_if.sink     in_ch,
  tpi_out_if.source  out_ch
);

  // pipeline advances whenever the output register is free or being drained
  logic en;

  tpi_pkg::div_lane_t  front_lane [3];
  tpi_pkg::div_lane_t  div_lane [3];
  tpi_pkg::front_ctl_t front_ctl;

  // found and valid ride alongside the divider stages
  logic [tpi_pkg::QW-1:0] vpipe_r;
  logic [tpi_pkg::QW-1:0] fpipe_r;

  logic                      out_valid_r;
  tpi_pkg::out_item_t        out_data_r;
  tpi_pkg::out_item_t        out_data_nxt;
  logic signed [tpi_pkg::DISTW-1:0] coord [3];
  logic [2:0]                sat_lane;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  tpi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_item  (in_ch.data),
    .lane_o   (front_lane),
    .ctl_o    (front_ctl)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tpi_div u_div (
      .clk    (clk),
      .en     (en),
      .lane_i (front_lane[k]),
      .lane_o (div_lane[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
    end else if (en) begin
      vpipe_r <= {vpipe_r[tpi_pkg::QW-2:0], front_ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fpipe_r <= {fpipe_r[tpi_pkg::QW-2:0], front_ctl.found};
    end
  end

  // sign, clamp to 32 bits, and zero the point when the planes do not meet
  always_comb begin
    logic [tpi_pkg::QW-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = div_lane[k].q;
      if (div_lane[k].rneg) begin
        if (div_lane[k].ovf || q > 32'h8000_0000) begin
          coord[k]    = 32'sh8000_0000;
          sat_lane[k] = 1'b1;
        end else begin
          coord[k]    = $signed(32'h0 - q);
          sat_lane[k] = 1'b0;
        end
      end else begin
        if (div_lane[k].ovf || q > 32'h7fff_ffff) begin
          coord[k]    = 32'sh7fff_ffff;
          sat_lane[k] = 1'b1;
        end else begin
          coord[k]    = $signed(q);
          sat_lane[k] = 1'b0;
        end
      end
    end
    if (fpipe_r[tpi_pkg::QW-1]) begin
      out_data_nxt.px        = coord[0];
      out_data_nxt.py        = coord[1];
      out_data_nxt.pz        = coord[2];
      out_data_nxt.found     = 1'b1;
      out_data_nxt.saturated = |sat_lane;
    end else begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vpipe_r[tpi_pkg::QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // a beat without an intersection carries the origin and no clamp flag
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |->
      out_data_r.px == 0 && out_data_r.py == 0 && out_data_r.pz == 0 &&
      !out_data_r.saturated)
    else $error("not-found beat carries a nonzero point or clamp flag");

  // a valid nonzero triple product reaches the divider with a nonzero magnitude
  a_front_den: assert property (@(posedge clk) disable iff (!rst_n)
    front_ctl.valid && front_ctl.found |-> front_lane[0].dmag != '0)
    else $error("found item entered the divider with a zero divisor");

  // a beat is taken in only when the output register can move
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !out_valid_r || out_ch.ready)
    else $error("input beat accepted while the pipeline is frozen");

endmodule
